>>> sv/bld_pkg.sv
// bld_pkg: shared types, constants and tables of the bezier lattice deform block
// no dependencies; compiled first
`default_nettype none

package bld_pkg;

	localparam int COORD_BITS  = 20;
	localparam int CFG_BITS    = 3 * COORD_BITS;
	localparam int IDX_BITS    = 9;
	localparam int STORE_DEPTH = 1 << IDX_BITS;
	localparam int WFRAC       = 24;
	localparam int CREG_BITS   = 3;
	localparam int DEG_BITS    = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [CFG_BITS-1:0] cfg_word_t;

	// register indexes of the configuration channel
	typedef enum logic [CREG_BITS-1:0] {
		REG_BOX_MIN,
		REG_BOX_MAX,
		REG_INV_SIZE,
		REG_LAT_ORIGIN,
		REG_MESH_OFFSET,
		REG_LAT_DEGREE
	} reg_idx_t;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DEFORM = 1'b1;

	localparam logic [3*DEG_BITS-1:0] LAT_DEGREE_RESET = 9'd73;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NORM_MUL,
		S_NORM_WB,
		S_BERN_START,
		S_BERN_MUL,
		S_BERN_WB,
		S_BERN_SCALE,
		S_BERN_STORE,
		S_WIJ_MUL,
		S_WIJ_WB,
		S_W_MUL,
		S_W_WB,
		S_ACC,
		S_FINAL
	} state_t;

	// binomial coefficients, row n, column i
	localparam logic [5:0] CHOOSE_TAB [8][8] = '{
		'{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
		'{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
		'{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
	};

	// one coordinate lane of a packed three-lane word, x in the low lane
	function automatic coord_t lane_of(input cfg_word_t w, input logic [1:0] c);
		coord_t r;
		unique case (c)
			2'd0: r = w[0 +: COORD_BITS];
			2'd1: r = w[COORD_BITS +: COORD_BITS];
			default: r = w[2*COORD_BITS +: COORD_BITS];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/bld_if.sv
// bld_if: item, result and configuration channel interfaces
// depends on bld_pkg
`default_nettype none

interface bld_item_if import bld_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [IDX_BITS-1:0] point_index;
	coord_t              coord_x;
	coord_t              coord_y;
	coord_t              coord_z;

	modport source (output valid, opcode, point_index, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, opcode, point_index, coord_x, coord_y, coord_z, output ready);
endinterface

interface bld_result_if import bld_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic   inside_box;

	modport source (output valid, out_x, out_y, out_z, inside_box, input ready);
	modport sink (input valid, out_x, out_y, out_z, inside_box, output ready);
endinterface

interface bld_cfg_if import bld_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CREG_BITS-1:0] index;
	cfg_word_t            data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/bezier_lattice_deform.sv
// bezier_lattice_deform: trivariate bezier lattice vertex deformer, top level
// depends on bld_pkg and the channel interfaces in bld_if
//
// channel  role    transfer moves
// item     sink    opcode, point_index, coord_x/y/z (load point or deform vertex)
// result   source  out_x/y/z, inside_box (one per deform item)
// cfg      sink    index, data (always ready)
//
// a load is taken in the idle state. a deform outside the box goes straight to the
// final state; inside it first normalizes each axis, then forms the bernstein weights
// per axis, then per lattice point forms its weight and accumulates the three lanes,
// forming the (i,j) product once per pair, all on the one shared 27x27 multiplier.
// reset clears control and configuration; the lattice memory is not cleared. a
// stalled result holds in the output register while the next item is taken.
`default_nettype none

module bezier_lattice_deform import bld_pkg::*; #(
	parameter int MAX_DEGREE = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	bld_item_if.sink      item,
	bld_result_if.source  result,
	bld_cfg_if.sink       cfg
);

	localparam logic [DEG_BITS-1:0] MaxDeg = DEG_BITS'(MAX_DEGREE);

	function automatic logic [DEG_BITS-1:0] clamp_deg(input logic [DEG_BITS-1:0] d);
		logic [DEG_BITS-1:0] r;
		r = d;
		if (r == '0) r = DEG_BITS'(1);
		if (r > MaxDeg) r = MaxDeg;
		return r;
	endfunction

	// configuration registers
	cfg_word_t box_min_q, box_max_q, inv_size_q, lat_origin_q, mesh_offset_q;
	logic [3*DEG_BITS-1:0] lat_degree_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_q     <= '0;
			box_max_q     <= '0;
			inv_size_q    <= '0;
			lat_origin_q  <= '0;
			mesh_offset_q <= '0;
			lat_degree_q  <= LAT_DEGREE_RESET;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_BOX_MIN:     box_min_q     <= cfg.data;
				REG_BOX_MAX:     box_max_q     <= cfg.data;
				REG_INV_SIZE:    inv_size_q    <= cfg.data;
				REG_LAT_ORIGIN:  lat_origin_q  <= cfg.data;
				REG_MESH_OFFSET: mesh_offset_q <= cfg.data;
				REG_LAT_DEGREE:  lat_degree_q  <= cfg.data[3*DEG_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic [DEG_BITS-1:0] nx, ny, nz;
	assign nx = clamp_deg(lat_degree_q[0 +: DEG_BITS]);
	assign ny = clamp_deg(lat_degree_q[DEG_BITS +: DEG_BITS]);
	assign nz = clamp_deg(lat_degree_q[2*DEG_BITS +: DEG_BITS]);

	state_t state_q, state_d;

	logic item_xfer, load_xfer, deform_xfer;
	assign item.ready  = (state_q == S_IDLE);
	assign item_xfer   = item.valid && item.ready;
	assign load_xfer   = item_xfer && (item.opcode == OP_LOAD);
	assign deform_xfer = item_xfer && (item.opcode == OP_DEFORM);

	// box test on the incoming vertex
	logic inside_in;
	always_comb begin
		inside_in = 1'b1;
		if (item.coord_x < lane_of(box_min_q, 2'd0) || item.coord_x > lane_of(box_max_q, 2'd0))
			inside_in = 1'b0;
		if (item.coord_y < lane_of(box_min_q, 2'd1) || item.coord_y > lane_of(box_max_q, 2'd1))
			inside_in = 1'b0;
		if (item.coord_z < lane_of(box_min_q, 2'd2) || item.coord_z > lane_of(box_max_q, 2'd2))
			inside_in = 1'b0;
	end

	// datapath registers
	cfg_word_t                  pos_q;
	logic                       inside_q;
	logic [1:0]                 axis_q, c_q;
	logic [DEG_BITS-1:0]        bi_q, r_q, i_q, j_q, k_q;
	logic [IDX_BITS-1:0]        addr_q;
	logic [2:0][24:0]           u_q;
	logic [24:0]                p_q;
	logic [7:0][25:0]           bx_q, by_q, bz_q;
	logic [25:0]                wij_q, w_q;
	logic signed [53:0]         prod_q;
	logic signed [57:0]         acc_q [3];
	cfg_word_t                  rd_q;
	cfg_word_t                  lattice_mem [STORE_DEPTH];

	// lattice store: write on load, read every cycle at the walk address
	always_ff @(posedge clk) begin
		if (load_xfer)
			lattice_mem[item.point_index] <= {item.coord_z, item.coord_y, item.coord_x};
		rd_q <= lattice_mem[addr_q];
	end

	// operand preparation
	logic [DEG_BITS-1:0] n_axis;
	logic [20:0]         d_norm;
	logic [24:0]         u_cur, um_cur, bern_op;
	logic signed [20:0]  diff_acc;
	logic [5:0]          choose_val;
	coord_t              pos_lane, min_lane, rd_lane, org_lane;

	always_comb begin
		unique case (axis_q)
			2'd0: n_axis = nx;
			2'd1: n_axis = ny;
			default: n_axis = nz;
		endcase
		pos_lane = lane_of(pos_q, axis_q);
		min_lane = lane_of(box_min_q, axis_q);
		rd_lane  = lane_of(rd_q, c_q);
		org_lane = lane_of(lat_origin_q, c_q);
		d_norm = {pos_lane[COORD_BITS-1], pos_lane} - {min_lane[COORD_BITS-1], min_lane};
		u_cur   = u_q[axis_q];
		um_cur  = (25'd1 << WFRAC) - u_cur;
		bern_op = (r_q < (n_axis - bi_q)) ? um_cur : u_cur;
		diff_acc = {rd_lane[COORD_BITS-1], rd_lane} - {org_lane[COORD_BITS-1], org_lane};
		choose_val = CHOOSE_TAB[n_axis][bi_q];
	end

	// shared multiplier operand select
	logic signed [26:0] mul_a, mul_b;
	always_comb begin
		unique case (state_q)
			S_NORM_MUL: begin
				mul_a = {6'b0, d_norm};
				mul_b = {7'b0, lane_of(inv_size_q, axis_q)};
			end
			S_BERN_MUL: begin
				mul_a = {2'b0, p_q};
				mul_b = {2'b0, bern_op};
			end
			S_BERN_SCALE: begin
				mul_a = {21'b0, choose_val};
				mul_b = {2'b0, p_q};
			end
			S_WIJ_MUL: begin
				mul_a = {1'b0, bx_q[i_q]};
				mul_b = {1'b0, by_q[j_q]};
			end
			S_W_MUL: begin
				mul_a = {1'b0, wij_q};
				mul_b = {1'b0, bz_q[k_q]};
			end
			S_ACC: begin
				mul_a = {1'b0, w_q};
				mul_b = {{6{diff_acc[20]}}, diff_acc};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// rounding of the registered product
	logic [53:0] prod_rnd24, prod_rnd10;
	logic [25:0] rnd24;
	logic [16:0] u16;
	logic [24:0] u24;
	always_comb begin
		prod_rnd24 = prod_q + (54'd1 << (WFRAC - 1));
		rnd24      = prod_rnd24[WFRAC +: 26];
		prod_rnd10 = prod_q + 54'd512;
		u16        = (prod_rnd10[53:10] > 44'd65536) ? 17'd65536 : prod_rnd10[26:10];
		u24        = {u16, 8'b0};
	end

	// final position per lane with mesh offset and saturation
	coord_t res_lane [3];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			logic signed [57:0] acc_rnd;
			logic signed [35:0] base;
			logic signed [35:0] total;
			// weighted sum scaled down, ties toward plus infinity
			acc_rnd = acc_q[l] + 58'sd8388608;
			if (inside_q)
				base = 36'(signed'(lane_of(box_min_q, 2'(l))))
					+ 36'(signed'(acc_rnd[57:WFRAC]));
			else
				base = 36'(signed'(lane_of(pos_q, 2'(l))));
			total = base + 36'(signed'(lane_of(mesh_offset_q, 2'(l))));
			if (total > 36'sd524287)
				res_lane[l] = coord_t'(20'sd524287);
			else if (total < -36'sd524288)
				res_lane[l] = coord_t'(-20'sd524288);
			else
				res_lane[l] = total[COORD_BITS-1:0];
		end
	end

	logic out_valid_q, out_load;
	assign out_load = (state_q == S_FINAL) && (!out_valid_q || result.ready);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (deform_xfer) state_d = inside_in ? S_NORM_MUL : S_FINAL;
			end
			S_NORM_MUL: state_d = S_NORM_WB;
			S_NORM_WB: state_d = (axis_q == 2'd2) ? S_BERN_START : S_NORM_MUL;
			S_BERN_START: state_d = S_BERN_MUL;
			S_BERN_MUL: state_d = S_BERN_WB;
			S_BERN_WB: state_d = (r_q == n_axis - DEG_BITS'(1)) ? S_BERN_SCALE : S_BERN_MUL;
			S_BERN_SCALE: state_d = S_BERN_STORE;
			S_BERN_STORE: begin
				if (bi_q == n_axis && axis_q == 2'd2) state_d = S_WIJ_MUL;
				else                                  state_d = S_BERN_START;
			end
			S_WIJ_MUL: state_d = S_WIJ_WB;
			S_WIJ_WB: state_d = S_W_MUL;
			S_W_MUL: state_d = S_W_WB;
			S_W_WB: state_d = S_ACC;
			S_ACC: begin
				if (c_q == 2'd3) begin
					if (k_q != nz)      state_d = S_W_MUL;
					else if (j_q != ny) state_d = S_WIJ_MUL;
					else if (i_q != nx) state_d = S_WIJ_MUL;
					else                state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath updates under the sequencer
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				if (deform_xfer) begin
					pos_q    <= {item.coord_z, item.coord_y, item.coord_x};
					inside_q <= inside_in;
					axis_q   <= 2'd0;
				end
			end
			S_NORM_WB: begin
				u_q[axis_q] <= u24;
				axis_q      <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
				bi_q        <= '0;
			end
			S_BERN_START: begin
				p_q <= 25'd1 << WFRAC;
				r_q <= '0;
			end
			S_BERN_WB: begin
				p_q <= rnd24[24:0];
				r_q <= r_q + DEG_BITS'(1);
			end
			S_BERN_STORE: begin
				unique case (axis_q)
					2'd0: bx_q[bi_q] <= prod_q[25:0];
					2'd1: by_q[bi_q] <= prod_q[25:0];
					default: bz_q[bi_q] <= prod_q[25:0];
				endcase
				if (bi_q == n_axis) begin
					bi_q   <= '0;
					axis_q <= axis_q + 2'd1;
					i_q    <= '0;
					j_q    <= '0;
					k_q    <= '0;
					addr_q <= '0;
					for (int l = 0; l < 3; l++) acc_q[l] <= '0;
				end else begin
					bi_q <= bi_q + DEG_BITS'(1);
				end
			end
			S_WIJ_WB: wij_q <= rnd24;
			S_W_WB: begin
				w_q <= rnd24;
				c_q <= 2'd0;
			end
			S_ACC: begin
				if (c_q != 2'd0)
					acc_q[2'(c_q - 2'd1)] <= acc_q[2'(c_q - 2'd1)] + 58'(prod_q);
				c_q <= c_q + 2'd1;
				if (c_q == 2'd3) begin
					addr_q <= addr_q + IDX_BITS'(1);
					if (k_q != nz) begin
						k_q <= k_q + DEG_BITS'(1);
					end else begin
						k_q <= '0;
						if (j_q != ny) begin
							j_q <= j_q + DEG_BITS'(1);
						end else begin
							j_q <= '0;
							i_q <= i_q + DEG_BITS'(1);
						end
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	coord_t out_x_q, out_y_q, out_z_q;
	logic   out_inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q      <= res_lane[0];
			out_y_q      <= res_lane[1];
			out_z_q      <= res_lane[2];
			out_inside_q <= inside_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_x      = out_x_q;
	assign result.out_y      = out_y_q;
	assign result.out_z      = out_z_q;
	assign result.inside_box = out_inside_q;

`ifndef SYNTHESIS
	a_busy_after_deform: assert property (@(posedge clk) disable iff (!arst_n)
		deform_xfer |=> !item.ready)
		else $error("item taken while a deform is in progress");
	a_bern_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BERN_MUL) |-> (r_q < n_axis))
		else $error("bernstein product count overran the degree");
	a_acc_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC && c_q == 2'd0) |-> ($past(state_q) == S_W_WB))
		else $error("accumulate lanes started without a fresh weight");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench: self-checking bench for the bezier lattice deform block
// depends on bld_pkg, the channel interfaces in bld_if and bezier_lattice_deform
`default_nettype none

module testbench;
	import bld_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// predicts deformed vertices and holds the results still owed by the block
	class deform_scoreboard;
		typedef struct {
			coord_t x;
			coord_t y;
			coord_t z;
			logic   in_box;
		} vertex_t;

		cfg_word_t      box_min, box_max, inv_size, origin, offset;
		logic [8:0]     degree;
		coord_t         lattice [STORE_DEPTH][3];
		vertex_t        owed_q[$];
		int             errors;

		function new();
			box_min = '0;
			box_max = '0;
			inv_size = '0;
			origin = '0;
			offset = '0;
			degree = LAT_DEGREE_RESET;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t r, cfg_word_t d);
			case (r)
				REG_BOX_MIN: box_min = d;
				REG_BOX_MAX: box_max = d;
				REG_INV_SIZE: inv_size = d;
				REG_LAT_ORIGIN: origin = d;
				REG_MESH_OFFSET: offset = d;
				REG_LAT_DEGREE: degree = d[8:0];
				default: ;
			endcase
		endfunction

		function longint sfield(cfg_word_t w, int c);
			coord_t v;
			v = w[c*COORD_BITS +: COORD_BITS];
			return longint'(v);
		endfunction

		function longint unsigned qmul(longint unsigned a, longint unsigned b);
			return (a * b + (64'd1 << (WFRAC - 1))) >> WFRAC;
		endfunction

		// u in Q.24, saturated to one
		function longint unsigned norm_q24(longint diff, longint unsigned inv);
			longint unsigned lim, p, u16;
			lim = 64'd1 << 26;
			if (inv != 0 && longint'(diff) > longint'(lim / inv))
				p = lim;
			else
				p = longint'(diff) * inv;
			u16 = (p + 64'd512) >> 10;
			if (u16 > 64'd65536)
				u16 = 64'd65536;
			return u16 << (WFRAC - 16);
		endfunction

		function void weights(int n, longint unsigned u, output longint unsigned b[8]);
			longint unsigned one, um, p;
			one = 64'd1 << WFRAC;
			um = one - u;
			for (int i = 0; i < 8; i++)
				b[i] = 0;
			for (int i = 0; i <= n; i++) begin
				p = one;
				for (int r = 0; r < n - i; r++)
					p = qmul(p, um);
				for (int r = 0; r < i; r++)
					p = qmul(p, u);
				b[i] = longint'(CHOOSE_TAB[n][i]) * p;
			end
		endfunction

		function longint div_round(longint t);
			t = t + (64'sd1 <<< (WFRAC - 1));
			if (t >= 0)
				return t >>> WFRAC;
			return -longint'((unsigned'(-t) + (64'd1 << WFRAC) - 1) >> WFRAC);
		endfunction

		function longint clamp(longint v);
			if (v > 524287)
				return 524287;
			if (v < -524288)
				return -524288;
			return v;
		endfunction

		// an accepted item: a load updates the lattice, a deform owes a result
		function void note_item(logic op, logic [8:0] idx, coord_t x, coord_t y, coord_t z);
			longint pos[3], res[3], acc[3], org[3], w;
			longint unsigned bw[3][8], wij, tmp[8];
			int nd[3], a;
			logic ins;
			vertex_t v;
			if (op == OP_LOAD) begin
				lattice[idx][0] = x;
				lattice[idx][1] = y;
				lattice[idx][2] = z;
				return;
			end
			pos[0] = x;
			pos[1] = y;
			pos[2] = z;
			ins = 1'b1;
			for (int c = 0; c < 3; c++)
				if (pos[c] < sfield(box_min, c) || pos[c] > sfield(box_max, c))
					ins = 1'b0;
			if (ins) begin
				for (int c = 0; c < 3; c++) begin
					nd[c] = degree[3*c +: 3];
					if (nd[c] < 1)
						nd[c] = 1;
					org[c] = sfield(origin, c);
					acc[c] = 0;
					weights(nd[c], norm_q24(pos[c] - sfield(box_min, c),
						inv_size[c*COORD_BITS +: COORD_BITS]), tmp);
					bw[c] = tmp;
				end
				a = 0;
				for (int i = 0; i <= nd[0]; i++)
					for (int j = 0; j <= nd[1]; j++) begin
						wij = qmul(bw[0][i], bw[1][j]);
						for (int k = 0; k <= nd[2]; k++) begin
							w = longint'(qmul(wij, bw[2][k]));
							for (int c = 0; c < 3; c++)
								acc[c] += w * (longint'(lattice[a][c]) - org[c]);
							a++;
						end
					end
				for (int c = 0; c < 3; c++)
					res[c] = sfield(box_min, c) + div_round(acc[c]);
			end else begin
				for (int c = 0; c < 3; c++)
					res[c] = pos[c];
			end
			v.x = coord_t'(clamp(res[0] + sfield(offset, 0)));
			v.y = coord_t'(clamp(res[1] + sfield(offset, 1)));
			v.z = coord_t'(clamp(res[2] + sfield(offset, 2)));
			v.in_box = ins;
			owed_q.push_back(v);
		endfunction

		function void check_result(coord_t x, coord_t y, coord_t z, logic ins);
			vertex_t e;
			if (owed_q.size() == 0) begin
				$error("result with nothing owed: %0d %0d %0d %b", x, y, z, ins);
				errors++;
				return;
			end
			e = owed_q.pop_front();
			if (x !== e.x) begin
				$error("out_x expected %0d actual %0d", e.x, x);
				errors++;
			end
			if (y !== e.y) begin
				$error("out_y expected %0d actual %0d", e.y, y);
				errors++;
			end
			if (z !== e.z) begin
				$error("out_z expected %0d actual %0d", e.z, z);
				errors++;
			end
			if (ins !== e.in_box) begin
				$error("inside_box expected %b actual %b", e.in_box, ins);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bld_item_if   item();
	bld_result_if result();
	bld_cfg_if    cfg();

	bezier_lattice_deform u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	deform_scoreboard sb = new();

	int     snd_idle;
	int     rcv_idle;
	int     hold_cycles;
	int     n_sent;
	longint box_lo[3];
	longint box_span[3];

	localparam int ITEMS_PLANNED = 1170;

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// receiver readiness, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result.ready = 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			result.ready = ($urandom_range(99) >= rcv_idle);
		end
	end

	// result transfer check
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_result(result.out_x, result.out_y, result.out_z, result.inside_box);
	end

	// idling profile follows progress through the run
	task automatic pick_idling();
		int stage;
		stage = n_sent * 3 / ITEMS_PLANNED;
		if (stage == 0) begin
			snd_idle = 35;
			rcv_idle = 53;
		end else if (stage == 1) begin
			snd_idle = 53;
			rcv_idle = 35;
		end else begin
			snd_idle = 0;
			rcv_idle = 0;
		end
	endtask

	task automatic write_reg(reg_idx_t r, cfg_word_t d);
		cfg.valid = 1'b1;
		cfg.index = r;
		cfg.data = d;
		do
			@(posedge clk);
		while (!cfg.ready);
		sb.set_reg(r, d);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic send_item(logic op, logic [8:0] idx, coord_t x, coord_t y, coord_t z);
		pick_idling();
		while ($urandom_range(99) < snd_idle)
			@(negedge clk);
		item.valid = 1'b1;
		item.opcode = op;
		item.point_index = idx;
		item.coord_x = x;
		item.coord_y = y;
		item.coord_z = z;
		do
			@(posedge clk);
		while (!item.ready);
		sb.note_item(op, idx, x, y, z);
		n_sent++;
		@(negedge clk);
		item.valid = 1'b0;
	endtask

	// wait for every owed result, then let a trailing load settle
	task automatic wait_drained();
		while (sb.owed_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic coord_t rnd_coord();
		return coord_t'($urandom);
	endfunction

	// vertex mostly within the span of the current box
	function automatic coord_t near_box(int c);
		if ($urandom_range(3) == 0)
			return rnd_coord();
		return coord_t'(box_lo[c] + longint'($urandom_range(0, int'(box_span[c]))));
	endfunction

	// program every register for one phase
	task automatic setup_phase(int p, logic [8:0] deg);
		cfg_word_t mn, mx, inv, org, off;
		longint s, lo;
		for (int c = 0; c < 3; c++) begin
			if (p == 1) begin
				lo = -524288;
				s = 1048575;
			end else begin
				s = $urandom_range(64, 200000);
				lo = longint'($urandom_range(0, int'(1048575 - s))) - 524288;
			end
			box_lo[c] = lo;
			box_span[c] = s;
			mn[c*COORD_BITS +: COORD_BITS] = coord_t'(lo);
			mx[c*COORD_BITS +: COORD_BITS] = coord_t'(p == 2 ? lo - 1 : lo + s);
			if (p % 3 == 0 && p != 0)
				inv[c*COORD_BITS +: COORD_BITS] = coord_t'($urandom);
			else
				inv[c*COORD_BITS +: COORD_BITS] = coord_t'((64'd1 << 26) / s);
			org[c*COORD_BITS +: COORD_BITS] = rnd_coord();
			if (p == 1)
				off[c*COORD_BITS +: COORD_BITS] = coord_t'(524287);
			else if (p == 4)
				off[c*COORD_BITS +: COORD_BITS] = coord_t'(-524288);
			else if (p % 2 == 0)
				off[c*COORD_BITS +: COORD_BITS] = rnd_coord();
			else
				off[c*COORD_BITS +: COORD_BITS] = coord_t'($urandom_range(0, 2000) - 1000);
		end
		write_reg(REG_BOX_MIN, mn);
		write_reg(REG_BOX_MAX, mx);
		write_reg(REG_INV_SIZE, inv);
		write_reg(REG_LAT_ORIGIN, org);
		write_reg(REG_MESH_OFFSET, off);
		write_reg(REG_LAT_DEGREE, cfg_word_t'(deg));
	endtask

	task automatic random_items(int count, int pause_at);
		for (int n = 0; n < count; n++) begin
			if (n == pause_at)
				wait_drained();
			if ($urandom_range(4) == 0)
				send_item(OP_LOAD, 9'($urandom), rnd_coord(), rnd_coord(), rnd_coord());
			else
				send_item(OP_DEFORM, 9'($urandom), near_box(0), near_box(1), near_box(2));
		end
	endtask

	// stop a hung run
	initial begin
		#80ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [8:0] deg_list [9];
		deg_list = '{9'o111, 9'o000, 9'o121, 9'o212, 9'o111, 9'o131, 9'o777, 9'o222, 9'o117};
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.opcode = OP_LOAD;
		item.point_index = '0;
		item.coord_x = '0;
		item.coord_y = '0;
		item.coord_z = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_BOX_MIN;
		cfg.data = '0;
		hold_cycles = 0;
		n_sent = 0;
		snd_idle = 35;
		rcv_idle = 53;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every lattice entry is written before any deform reads it
		for (int i = 0; i < STORE_DEPTH; i++)
			send_item(OP_LOAD, 9'(i), rnd_coord(), rnd_coord(), rnd_coord());

		// directed: corners of the box, field extremes, pass-through
		setup_phase(0, deg_list[0]);
		send_item(OP_LOAD, 9'd0, coord_t'(-524288), coord_t'(524287), coord_t'(-524288));
		send_item(OP_LOAD, 9'd511, coord_t'(524287), coord_t'(-524288), coord_t'(524287));
		send_item(OP_LOAD, 9'd7, coord_t'(0), coord_t'(-1), coord_t'(1));
		send_item(OP_DEFORM, 9'd0, coord_t'(box_lo[0]), coord_t'(box_lo[1]),
			coord_t'(box_lo[2]));
		send_item(OP_DEFORM, 9'd511, coord_t'(box_lo[0] + box_span[0]),
			coord_t'(box_lo[1] + box_span[1]), coord_t'(box_lo[2] + box_span[2]));
		send_item(OP_DEFORM, 9'd0, coord_t'(box_lo[0] - 1), coord_t'(box_lo[1]),
			coord_t'(box_lo[2]));
		send_item(OP_DEFORM, 9'd0, coord_t'(box_lo[0]), coord_t'(box_lo[1] + box_span[1] + 1),
			coord_t'(box_lo[2]));
		send_item(OP_DEFORM, 9'd0, coord_t'(-524288), coord_t'(-524288), coord_t'(-524288));
		send_item(OP_DEFORM, 9'd0, coord_t'(524287), coord_t'(524287), coord_t'(524287));
		send_item(OP_DEFORM, 9'd0, coord_t'(box_lo[0] + box_span[0] / 2),
			coord_t'(box_lo[1] + box_span[1] / 2), coord_t'(box_lo[2] + box_span[2] / 2));
		random_items(8, -1);
		wait_drained();

		// random phases over several register settings
		for (int p = 1; p < 9; p++) begin
			setup_phase(p, deg_list[p]);
			if (p == 4)
				hold_cycles = 600;
			random_items(deg_list[p] == 9'o777 ? 10 : 90, p == 5 ? 50 : -1);
			wait_drained();
		end

		// a trailing load may still be in flight
		repeat (50) @(negedge clk);
		if (sb.owed_q.size() != 0) begin
			$error("%0d results never arrived", sb.owed_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
sv/bld_pkg.sv
sv/bld_if.sv
sv/bezier_lattice_deform.sv
dv/testbench.sv
